@@ hdl/cpk_pkg.sv @@
// Package for the CRC codeword packer: field widths, register indexes,
// reset values and the control record passed from front end to packer.
// No dependencies.
`default_nettype none

package cpk_pkg;

  localparam int MAX_GEN_BITS = 16;
  localparam int BYTE_W       = 8;
  localparam int PAD_W        = 3;
  localparam int GEN_BITS_W   = 16;
  localparam int GEN_LEN_W    = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GEN_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DW_MODE  = 2'd2;

  localparam logic [GEN_BITS_W-1:0] GEN_BITS_RST = 16'd11;
  localparam logic [GEN_LEN_W-1:0]  GEN_LEN_RST  = 5'd4;
  localparam logic                  DW_MODE_RST  = 1'b1;

  // Dataword mode codes
  localparam logic MODE_NIBBLE = 1'b0;
  localparam logic MODE_BYTE   = 1'b1;

  // Opcode values
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  typedef struct packed {
    logic             is_start;
    logic [PAD_W-1:0] pad;
  } cpk_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/cpk_ifs.sv @@
// Channel interfaces of the CRC codeword packer: input items, result
// items and configuration writes. Depends on cpk_pkg.
`default_nettype none

interface cpk_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  logic [2:0] pad_bits;

  modport source (output valid, opcode, data_byte, pad_bits, input ready);
  modport sink   (input valid, opcode, data_byte, pad_bits, output ready);
endinterface

interface cpk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

interface cpk_cfg_if;
  import cpk_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] value;

  modport source (output valid, index, value, input ready);
  modport sink   (input valid, index, value, output ready);
endinterface

`default_nettype wire

@@ hdl/cpk_front.sv @@
// Front end: configuration registers, item intake and codeword building
// by modulo-2 division. Depends on cpk_pkg and cpk_ifs.
`default_nettype none

module cpk_front #(
  parameter int MAX_GENERATOR_BITS = cpk_pkg::MAX_GEN_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  cpk_in_if.sink                  in_i,
  cpk_cfg_if.sink                 cfg_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output cpk_pkg::cpk_ctrl_t      push_ctrl_o,
  output logic [2*MAX_GENERATOR_BITS+5:0]               push_bits_o,
  output logic [$clog2(2*MAX_GENERATOR_BITS+7)-1:0]     push_nbits_o
);
  import cpk_pkg::*;

  localparam int MG     = MAX_GENERATOR_BITS;
  localparam int GW     = $clog2(MG + 1);
  localparam int WW     = BYTE_W + MG - 1;   // codeword of a byte dataword
  localparam int HW     = MG + 3;            // codeword of a nibble dataword
  localparam int CW_TOT = 2 * HW;
  localparam int NW     = $clog2(CW_TOT + 1);

  logic [GEN_BITS_W-1:0] gen_bits_q;
  logic [GEN_LEN_W-1:0]  gen_len_q;
  logic                  dw_mode_q;

  logic [GW-1:0] g_eff;
  logic [MG-1:0] gen_ext, gen_mask, gen_al;
  logic [WW-1:0] cw_byte, cw_hi, cw_lo;
  logic [NW-1:0] nib_len;

  // Long division in a frame where the generator sits at the top of MG bits
  function automatic logic [WW-1:0] div_cw(input logic [7:0] d,
                                           input logic [MG-1:0] g_a);
    logic [WW-1:0] sh;
    logic [WW-1:0] w;
    logic [WW-1:0] gx;
    sh = WW'(d) << (MG - 1);
    gx = WW'(g_a);
    w  = sh;
    for (int j = BYTE_W - 1; j >= 0; j--) begin
      if (w[j+MG-1]) w = w ^ (gx << j);
    end
    return sh | w;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_bits_q <= GEN_BITS_RST;
      gen_len_q  <= GEN_LEN_RST;
      dw_mode_q  <= DW_MODE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_GEN_BITS: gen_bits_q <= cfg_i.value[GEN_BITS_W-1:0];
        REG_GEN_LEN:  gen_len_q  <= cfg_i.value[GEN_LEN_W-1:0];
        REG_DW_MODE:  dw_mode_q  <= cfg_i.value[0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (gen_len_q < GEN_LEN_W'(2)) begin
      g_eff = GW'(2);
    end else if (32'(gen_len_q) > MG) begin
      g_eff = GW'(MG);
    end else begin
      g_eff = GW'(gen_len_q);
    end
  end

  assign gen_ext  = MG'(gen_bits_q);
  assign gen_mask = ~({MG{1'b1}} << g_eff);
  assign gen_al   = (gen_ext & gen_mask) << (GW'(MG) - g_eff);

  assign cw_byte = div_cw(in_i.data_byte, gen_al);
  assign cw_hi   = div_cw({4'b0, in_i.data_byte[7:4]}, gen_al);
  assign cw_lo   = div_cw({4'b0, in_i.data_byte[3:0]}, gen_al);
  assign nib_len = NW'(3) + NW'(g_eff);

  // Left-align the codeword bits; bits below the count stay zero
  always_comb begin
    push_ctrl_o.is_start = (in_i.opcode == OP_START);
    push_ctrl_o.pad      = in_i.pad_bits;
    unique case (dw_mode_q)
      MODE_BYTE: begin
        push_bits_o  = CW_TOT'(cw_byte) << (CW_TOT - WW);
        push_nbits_o = NW'(7) + NW'(g_eff);
      end
      default: begin
        push_bits_o  = {cw_hi[HW-1:0], HW'(0)} | ({cw_lo[HW-1:0], HW'(0)} >> nib_len);
        push_nbits_o = nib_len << 1;
      end
    endcase
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

`default_nettype wire

@@ hdl/cpk_fifo.sv @@
// Short queue between front end and packer, two entries deep.
// Depends on cpk_pkg.
`default_nettype none

module cpk_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import cpk_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hdl/cpk_back.sv @@
// Back end: MSB-first byte packer with output register. Merges queued
// codeword bits behind the held bits and emits one byte a cycle while
// out_o is ready. Depends on cpk_pkg and cpk_ifs.
`default_nettype none

module cpk_back #(
  parameter int MAX_GENERATOR_BITS = cpk_pkg::MAX_GEN_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  output logic                    q_pop_o,
  input  cpk_pkg::cpk_ctrl_t      q_ctrl_i,
  input  logic [2*MAX_GENERATOR_BITS+5:0]            q_bits_i,
  input  logic [$clog2(2*MAX_GENERATOR_BITS+7)-1:0]  q_nbits_i,
  cpk_out_if.source               out_o
);
  import cpk_pkg::*;

  localparam int CW_TOT = 2 * MAX_GENERATOR_BITS + 6;
  localparam int BW     = CW_TOT + BYTE_W;
  localparam int CNTW   = $clog2(BW + 1);

  logic [BW-1:0]     buf_q, buf_d, m_buf;
  logic [CNTW-1:0]   cnt_q, cnt_d, m_cnt;
  logic              ov_q, ov_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;
  logic              slot_free, room, take;

  assign slot_free = !ov_q || out_o.ready;
  assign room      = cnt_q < CNTW'(BYTE_W);
  // A start item needs the output slot at once; data bits can merge early
  assign take      = q_valid_i && room && (!q_ctrl_i.is_start || slot_free);
  assign q_pop_o   = take;

  always_comb begin
    m_buf  = buf_q;
    m_cnt  = cnt_q;
    buf_d  = buf_q;
    cnt_d  = cnt_q;
    ov_d   = ov_q && !out_o.ready;
    byte_d = byte_q;
    last_d = last_q;
    if (take && !q_ctrl_i.is_start) begin
      m_buf = buf_q | ({q_bits_i, BYTE_W'(0)} >> cnt_q[2:0]);
      m_cnt = cnt_q + CNTW'(q_nbits_i);
    end
    if (take && q_ctrl_i.is_start) begin
      // drop leftover bits, preload the pad zeros
      ov_d   = 1'b1;
      byte_d = BYTE_W'(q_ctrl_i.pad);
      last_d = 1'b1;
      buf_d  = '0;
      cnt_d  = CNTW'(q_ctrl_i.pad);
    end else if (m_cnt >= CNTW'(BYTE_W) && slot_free) begin
      ov_d   = 1'b1;
      byte_d = m_buf[BW-1 -: BYTE_W];
      last_d = m_cnt < CNTW'(2 * BYTE_W);
      buf_d  = m_buf << BYTE_W;
      cnt_d  = m_cnt - CNTW'(BYTE_W);
    end else begin
      buf_d = m_buf;
      cnt_d = m_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.last_of_run = last_q;

endmodule

`default_nettype wire

@@ hdl/crc_codeword_packer.sv @@
// Top level of the CRC codeword packer: front end, queue and byte packer.
// Depends on cpk_pkg, cpk_ifs, cpk_front, cpk_fifo and cpk_back.
//
//   channel | dir | carries                          | accepted when
//   in_i    | in  | opcode, data_byte, pad_bits      | valid && ready
//   out_o   | out | out_byte, last_of_run            | valid && ready
//   cfg_i   | in  | index, value (register write)    | valid && ready
//
// The front end builds the codewords of an item combinationally and takes a
// new item every cycle while the two-entry queue has room.
// The packer emits one byte per cycle while out_o is ready; an item yields
// up to five bytes in nibble mode with a 16-bit generator.
// Reset restores the register defaults and empties the packer; no clearing pass.
// The output register lets the packer keep merging while a byte waits.
`default_nettype none

module crc_codeword_packer #(
  parameter int MAX_GENERATOR_BITS = cpk_pkg::MAX_GEN_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpk_in_if.sink     in_i,
  cpk_out_if.source  out_o,
  cpk_cfg_if.sink    cfg_i
);
  import cpk_pkg::*;

  localparam int CW_TOT = 2 * MAX_GENERATOR_BITS + 6;
  localparam int NW     = $clog2(CW_TOT + 1);
  localparam int EW     = $bits(cpk_ctrl_t) + NW + CW_TOT;

  logic              push_valid, push_ready, q_valid, q_pop;
  cpk_ctrl_t         push_ctrl, q_ctrl;
  logic [CW_TOT-1:0] push_bits, q_bits;
  logic [NW-1:0]     push_nbits, q_nbits;
  logic [EW-1:0]     q_data;

  cpk_front #(.MAX_GENERATOR_BITS(MAX_GENERATOR_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_ctrl_o  (push_ctrl),
    .push_bits_o  (push_bits),
    .push_nbits_o (push_nbits)
  );

  cpk_fifo #(.WIDTH(EW)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_ctrl, push_nbits, push_bits}),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_data)
  );

  assign {q_ctrl, q_nbits, q_bits} = q_data;

  cpk_back #(.MAX_GENERATOR_BITS(MAX_GENERATOR_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_ctrl_i  (q_ctrl),
    .q_bits_i  (q_bits),
    .q_nbits_i (q_nbits),
    .out_o     (out_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("packer popped an empty queue");

  a_start_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_ctrl.is_start) |=>
      (out_o.valid && out_o.last_of_run &&
       out_o.out_byte == BYTE_W'($past(q_ctrl.pad))))
    else $error("start item did not produce its header byte");

  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_ready |-> q_valid)
    else $error("queue full but no head entry");

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking bench for crc_codeword_packer: runs directed and random items
// through the in, out and cfg channels and checks every packed byte.
// Depends on cpk_pkg, cpk_ifs and the RTL of crc_codeword_packer.
`timescale 1ns / 1ps

module tb;
  import cpk_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE       = 20;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 24;
  localparam int RAND_PHASES  = 8;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data;
    logic [2:0] pad;
  } enc_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } packed_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cpk_in_if  in_ch ();
  cpk_out_if out_ch ();
  cpk_cfg_if cfg_ch ();

  crc_codeword_packer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Register copies and packer state of the predictor
  logic [GEN_BITS_W-1:0] poly_bits = GEN_BITS_RST;
  logic [GEN_LEN_W-1:0]  poly_len  = GEN_LEN_RST;
  logic                  byte_mode = DW_MODE_RST;
  logic [7:0]            acc_bits  = '0;
  int                    acc_count = 0;

  enc_item_t    item_q[$];
  packed_byte_t expected_bytes[$];

  int items_queued  = 0;
  int items_done    = 0;
  int errors        = 0;
  int cycles        = 0;
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  bit in_taken      = 1'b0;

  always #HALF_PERIOD clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic int clamp_len(input logic [GEN_LEN_W-1:0] len);
    if (len < 2) return 2;
    if (len > MAX_GEN_BITS) return MAX_GEN_BITS;
    return int'(len);
  endfunction

  // Dataword shifted up with the long-division remainder below it
  function automatic logic [31:0] crc_codeword(input logic [7:0] dw, input int k,
                                               input int g);
    logic [31:0] poly;
    logic [31:0] shifted;
    logic [31:0] rem;
    poly    = 32'(poly_bits) & ((32'd1 << g) - 32'd1);
    shifted = 32'(dw) << (g - 1);
    rem     = shifted;
    for (int i = k; i > 0; i--) begin
      if (rem[i + g - 2]) rem ^= poly << (i - 1);
    end
    return (shifted | rem) & ((32'd1 << (k + g - 1)) - 32'd1);
  endfunction

  task automatic pack_codeword(input logic [31:0] cw, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      acc_bits = {acc_bits[6:0], cw[i]};
      acc_count++;
      if (acc_count == 8) begin
        expected_bytes.push_back('{value: acc_bits, last: 1'b0});
        acc_bits  = '0;
        acc_count = 0;
      end
    end
  endtask

  task automatic encode_item(input enc_item_t it);
    int           g;
    int           made_from;
    packed_byte_t tail;
    g         = clamp_len(poly_len);
    made_from = expected_bytes.size();
    if (it.opcode == OP_START) begin
      expected_bytes.push_back('{value: 8'(it.pad), last: 1'b1});
      acc_bits  = '0;
      acc_count = int'(it.pad);
    end else begin
      if (byte_mode == MODE_NIBBLE) begin
        pack_codeword(crc_codeword({4'b0, it.data[7:4]}, 4, g), 4 + g - 1);
        pack_codeword(crc_codeword({4'b0, it.data[3:0]}, 4, g), 4 + g - 1);
      end else begin
        pack_codeword(crc_codeword(it.data, 8, g), 8 + g - 1);
      end
      // flag the final byte of this item
      if (expected_bytes.size() > made_from) begin
        tail      = expected_bytes.pop_back();
        tail.last = 1'b1;
        expected_bytes.push_back(tail);
      end
    end
  endtask

  // Item driver: hold an offered item until taken, then offer the next or idle
  always @(negedge clk_i) begin
    enc_item_t it;
    if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (item_q.size() > 0 && $urandom_range(99) >= in_gap_pct) begin
        it = item_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= it.opcode;
        in_ch.data_byte <= it.data;
        in_ch.pad_bits  <= it.pad;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Predict on every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      encode_item('{opcode: in_ch.opcode, data: in_ch.data_byte, pad: in_ch.pad_bits});
      in_taken = 1'b1;
      items_done++;
    end
  end

  // Check every accepted byte against the oldest prediction
  always @(posedge clk_i) begin
    packed_byte_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %h with nothing pending", out_ch.out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (out_ch.out_byte !== want.value)
          report_mismatch($sformatf("out_byte %h, want %h", out_ch.out_byte, want.value));
        if (out_ch.last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %b, want %b",
                                    out_ch.last_of_run, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL crc_codeword_packer");
      $finish;
    end
  end

  task automatic queue_item(input logic op, input logic [7:0] data, input logic [2:0] pad);
    item_q.push_back('{opcode: op, data: data, pad: pad});
    items_queued++;
  endtask

  // Wait until all items are taken and all bytes are in, then let the block settle
  task automatic wait_drained();
    int guard;
    guard = 0;
    do begin
      @(negedge clk_i);
      guard++;
    end while (!(items_done == items_queued && expected_bytes.size() == 0)
               && guard < DRAIN_LIMIT);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.value <= val;
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    case (idx)
      REG_GEN_BITS: poly_bits = val;
      REG_GEN_LEN:  poly_len  = val[GEN_LEN_W-1:0];
      REG_DW_MODE:  byte_mode = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] bits, input logic [4:0] len, input logic mode);
    write_reg(REG_GEN_BITS, bits);
    write_reg(REG_GEN_LEN, 16'(len));
    write_reg(REG_DW_MODE, 16'(mode));
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_START;
    in_ch.data_byte = '0;
    in_ch.pad_bits  = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_GEN_BITS;
    cfg_ch.value    = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: data before any start, restart mid-stream, pad extremes
    queue_item(OP_DATA, 8'hA5, 3'd0);
    queue_item(OP_DATA, 8'h00, 3'd7);
    queue_item(OP_START, 8'hFF, 3'd7);
    queue_item(OP_DATA, 8'hFF, 3'd0);
    queue_item(OP_START, 8'h00, 3'd0);
    queue_item(OP_DATA, 8'h3C, 3'd0);
    wait_drained();

    // Shortest generator, bits above its length set
    write_all(16'hFFFF, 5'd2, MODE_NIBBLE);
    queue_item(OP_START, 8'h00, 3'd3);
    queue_item(OP_DATA, 8'h00, 3'd0);
    queue_item(OP_DATA, 8'hFF, 3'd0);
    queue_item(OP_START, 8'h00, 3'd6);
    queue_item(OP_DATA, 8'h81, 3'd0);
    wait_drained();

    // Longest generator in nibble mode: most bytes per item
    write_all(16'h8005, 5'd16, MODE_NIBBLE);
    queue_item(OP_START, 8'h00, 3'd5);
    queue_item(OP_DATA, 8'hFF, 3'd0);
    queue_item(OP_DATA, 8'h01, 3'd0);
    queue_item(OP_DATA, 8'h5A, 3'd0);
    wait_drained();

    // Length above the maximum, top generator bit clear
    write_all(16'h1234, 5'd31, MODE_BYTE);
    queue_item(OP_DATA, 8'h80, 3'd0);
    queue_item(OP_START, 8'h00, 3'd1);
    queue_item(OP_DATA, 8'h7F, 3'd0);
    wait_drained();

    // Lengths below the minimum, all-zero generator
    write_all(16'h0000, 5'd0, MODE_BYTE);
    queue_item(OP_DATA, 8'h55, 3'd0);
    queue_item(OP_DATA, 8'hAA, 3'd0);
    wait_drained();
    write_all(16'h0002, 5'd1, MODE_BYTE);
    queue_item(OP_DATA, 8'hC3, 3'd0);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      logic [4:0] len;
      logic       mode;
      case (p % 4)
        0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1: begin in_gap_pct = 67; out_stall_pct = 0;  end
        2: begin in_gap_pct = 0;  out_stall_pct = 67; end
        default: begin in_gap_pct = 33; out_stall_pct = 33; end
      endcase
      if (p == 0) begin
        len  = 5'd16;
        mode = MODE_NIBBLE;
      end else if (p == 1) begin
        len  = 5'd2;
        mode = MODE_BYTE;
      end else begin
        len  = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 2));
        mode = 1'($urandom_range(1));
      end
      write_all(16'($urandom_range(16'hFFFF)), len, mode);
      // mostly data with an occasional restart
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 0 || $urandom_range(99) < 12)
          queue_item(OP_START, 8'($urandom_range(255)), 3'($urandom_range(7)));
        else
          queue_item(OP_DATA, 8'($urandom_range(255)), 3'($urandom_range(7)));
      end
      wait_drained();
    end

    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
    if (errors == 0) begin
      $display("PASS crc_codeword_packer");
    end else begin
      $display("FAIL crc_codeword_packer");
    end
    $finish;
  end

endmodule
